// File: design/signed_int_to_decimal_ascii_macros.svh
// Assertion macros used by the signed_int_to_decimal_ascii controller (sidta_ctrl).
// Expects clk_i and rst_ni in the scope of each use.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define SIDTA_ASSERT(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("sidta assertion failed");

// Check that a trigger is followed by a consequence in the next cycle.
`define SIDTA_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("sidta sequence assertion failed");

`endif

// File: design/sidta_pkg.sv
// Package for signed_int_to_decimal_ascii: widths, character codes,
// controller states and the command/status structs. No dependencies.
`default_nettype none

package sidta_pkg;

  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int NUM_DIGITS  = 10;
  localparam int BCD_W       = NUM_DIGITS * DIGIT_W;
  localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
  localparam int CNT_W       = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_LOCATE,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  typedef struct packed {
    logic load;
    logic convert;
    logic locate;
    logic next_digit;
    logic emit_sign;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic neg;
    logic last_digit;
  } sts_t;

endpackage

`default_nettype wire

// File: design/sidta_stream_if.sv
// Valid/ready stream interfaces for the input value and the output characters.
// Depends on sidta_pkg for the payload widths.
`default_nettype none

interface sidta_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [sidta_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sidta_out_if;
  logic                          valid;
  logic                          ready;
  logic [sidta_pkg::CHAR_W-1:0]  character;
  logic                          last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// File: design/sidta_dp.sv
// Datapath: magnitude, shift-and-add-3 binary to BCD, digit pointer, character mux.
// Depends on sidta_pkg.
`default_nettype none

module sidta_dp (
  input  wire                                   clk_i,
  input  wire logic signed [sidta_pkg::VALUE_W-1:0] value_i,
  input  wire sidta_pkg::cmd_t                  cmd_i,
  output sidta_pkg::sts_t                       sts_o,
  output logic [sidta_pkg::CHAR_W-1:0]          character_o,
  output logic                                  last_o
);
  import sidta_pkg::*;

  logic [VALUE_W-1:0]     bin_q, bin_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [DIGIT_IDX_W-1:0] dig_q, dig_d;
  logic                   neg_q, neg_d;
  logic [VALUE_W-1:0]     raw;
  logic [BCD_W-1:0]       adj;
  logic [DIGIT_IDX_W-1:0] top;
  logic [DIGIT_W-1:0]     digits [NUM_DIGITS];

  assign raw = $unsigned(value_i);

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      digits[i] = bcd_q[i*DIGIT_W +: DIGIT_W];
    end
  end

  // Add 3 to every BCD digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digits[i] >= DIGIT_W'(5)) begin
        adj[i*DIGIT_W +: DIGIT_W] = digits[i] + DIGIT_W'(3);
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = digits[i];
      end
    end
  end

  // Highest nonzero digit; zero keeps one digit.
  always_comb begin
    top = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digits[i] != '0) begin
        top = DIGIT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    dig_d = dig_q;
    neg_d = neg_q;
    if (cmd_i.load) begin
      neg_d = raw[VALUE_W-1];
      bin_d = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
      bcd_d = '0;
      cnt_d = '0;
    end else if (cmd_i.convert) begin
      bcd_d = {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
      bin_d = {bin_q[VALUE_W-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.locate) begin
      dig_d = top;
    end else if (cmd_i.next_digit) begin
      dig_d = dig_q - DIGIT_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    cnt_q <= cnt_d;
    dig_q <= dig_d;
    neg_q <= neg_d;
  end

  assign sts_o.conv_done  = (cnt_q == CNT_W'(VALUE_W - 1));
  assign sts_o.neg        = neg_q;
  assign sts_o.last_digit = (dig_q == '0);

  assign character_o = cmd_i.emit_sign ? CHAR_MINUS
                                       : CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digits[dig_q]};
  assign last_o      = !cmd_i.emit_sign && (dig_q == '0);

endmodule

`default_nettype wire

// File: design/sidta_ctrl.sv
// Controller state machine: sequences load, conversion, digit search and output.
// Depends on sidta_pkg and signed_int_to_decimal_ascii_macros.svh.
`default_nettype none
`include "signed_int_to_decimal_ascii_macros.svh"

module sidta_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  input  wire sidta_pkg::sts_t  sts_i,
  output sidta_pkg::cmd_t       cmd_o
);
  import sidta_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (sts_i.conv_done) state_d = ST_LOCATE;
      end
      ST_LOCATE: begin
        state_d = sts_i.neg ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (out_ready_i) state_d = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (out_ready_i && sts_i.last_digit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.load   = in_valid_i;
      end
      ST_CONV: begin
        cmd_o.convert = 1'b1;
      end
      ST_LOCATE: begin
        cmd_o.locate = 1'b1;
      end
      ST_SIGN: begin
        out_valid_o     = 1'b1;
        cmd_o.emit_sign = 1'b1;
      end
      ST_DIGIT: begin
        out_valid_o      = 1'b1;
        cmd_o.next_digit = out_ready_i && !sts_i.last_digit;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  `SIDTA_ASSERT_NEXT(a_accept_starts_conv, in_valid_i && in_ready_o, state_q == ST_CONV)
  `SIDTA_ASSERT_NEXT(a_conv_ends_locate, (state_q == ST_CONV) && sts_i.conv_done,
                     state_q == ST_LOCATE)
  `SIDTA_ASSERT(a_sign_only_negative, (state_q != ST_SIGN) || sts_i.neg)
  `SIDTA_ASSERT(a_no_accept_while_out, !(in_ready_o && out_valid_o))

endmodule

`default_nettype wire

// File: design/signed_int_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Depends on sidta_pkg, sidta_stream_if, sidta_ctrl and sidta_dp.
//
//   port    dir   payload                 meaning
//   in_i    sink  value[31:0] signed      integer to convert
//   out_o   src   character[7:0], last    one ASCII character per transfer
//
// Steps: the input transfer, the shift-and-add-3 BCD conversion (one magnitude
// bit a cycle), a search for the leading digit, then the characters: a minus
// sign for a negative value, then the digits from the most significant.
// Reset clears only the controller state; the datapath is loaded per value.
// An output stall holds the current character; no new value is taken until
// the last character of the previous one has transferred.
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire          clk_i,
  input  wire          rst_ni,
  sidta_in_if.sink     in_i,
  sidta_out_if.source  out_o
);
  import sidta_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: owns the handshakes and issues at most one command per cycle.
  sidta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: magnitude, BCD digits and the character presented on out_o.
  sidta_dp u_dp (
    .clk_i       (clk_i),
    .value_i     (in_i.value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .character_o (out_o.character),
    .last_o      (out_o.last)
  );

endmodule

`default_nettype wire

// File: dv/signed_int_to_decimal_ascii_tb.sv
// Self-checking testbench for signed_int_to_decimal_ascii: drives 32-bit values and
// checks every ASCII character and last flag against typed-in text or a local decimal speller.
// Depends on sidta_pkg, sidta_stream_if and the signed_int_to_decimal_ascii RTL.
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_tb;
  import sidta_pkg::*;

  localparam int NUM_DIRECTED = 20;
  localparam int NUM_RANDOM   = 230;
  // Longest correct stretch with no transfer is a long sender gap followed by a
  // full conversion, or a long receiver stall; take that several times over.
  localparam int IDLE_LIMIT   = 2000;
  // Settle a little longer at the end, after the final drain.
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_char_t;

  // One directed row: the value and, where it is obvious, its typed-in text.
  // An empty spelling hands the row to the speller below.
  typedef struct {
    logic signed [VALUE_W-1:0] value;
    string                     spelled;
  } value_row_t;

  logic clk;
  logic rst_n;

  sidta_in_if  value_if ();
  sidta_out_if text_if ();

  signed_int_to_decimal_ascii dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (value_if),
    .out_o  (text_if)
  );

  text_char_t                text_due[$];         // characters still owed by the block
  string                     row_spelling_q[$];   // typed text per offered value
  logic signed [VALUE_W-1:0] value_in_flight;
  int unsigned               mismatches;
  int unsigned               idle_cycles;

  value_row_t directed_rows [NUM_DIRECTED] = '{
    '{32'sd0,           "0"},
    '{32'sd1,           "1"},
    '{-32'sd1,          "-1"},
    '{32'sd9,           "9"},
    '{32'sd10,          "10"},
    '{-32'sd42,         "-42"},
    '{32'sd2147483647,  "2147483647"},
    '{-32'sd2147483647, "-2147483647"},
    '{32'sh8000_0000,   "-2147483648"},
    '{32'sd1000000000,  "1000000000"},
    '{32'sd999999999,   ""},
    '{-32'sd1000000000, ""},
    '{32'sd99,          ""},
    '{-32'sd100,        ""},
    '{32'sd123456789,   ""},
    '{32'sh5555_5555,   ""},
    '{32'shAAAA_AAAA,   ""},
    '{32'sh0F0F_0F0F,   ""},
    '{32'shF0F0_F0F0,   ""},
    '{-32'sd9,          ""}
  };

  // 10 ns period: high and low halves of 5 ns each.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t value %0d: %s expected 0x%0h got 0x%0h",
             $time, value_in_flight, what, want, got);
    mismatches++;
  endtask

  // Spell a value in decimal, most significant character first. The magnitude
  // is taken unsigned, so the most negative value needs no special path.
  task automatic spell_decimal(input logic signed [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] mag;
    logic [DIGIT_W-1:0] digits [NUM_DIGITS];
    int                 nd;
    raw = value;
    mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
    nd  = 0;
    // Collect digits least significant first; zero still yields one digit.
    do begin
      digits[nd] = DIGIT_W'(mag % 10);
      nd++;
      mag = mag / 10;
    end while (mag != 0 && nd < NUM_DIGITS);
    if (raw[VALUE_W-1]) text_due.push_back('{character: CHAR_MINUS, last: 1'b0});
    for (int i = nd - 1; i >= 0; i--) begin
      text_due.push_back('{character: CHAR_ZERO + CHAR_W'(digits[i]), last: (i == 0)});
    end
  endtask

  // Queue a typed-in spelling, last flag on its final character.
  task automatic queue_spelling(input string spelled);
    for (int k = 0; k < spelled.len(); k++) begin
      text_due.push_back('{character: spelled[k], last: (k == spelled.len() - 1)});
    end
  endtask

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random value shaped to hit every digit count, decade edges and the extremes.
  function automatic logic signed [VALUE_W-1:0] random_value();
    longint unsigned    lo;
    longint unsigned    hi;
    int                 nd;
    logic [VALUE_W-1:0] mag;
    bit                 neg;
    neg = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // Uniform over the digit count, then over that decade.
        nd = $urandom_range(1, NUM_DIGITS);
        lo = 1;
        repeat (nd - 1) lo *= 10;
        hi = lo * 10 - 1;
        if (nd == 1) lo = 0;
        if (hi > 64'h8000_0000) hi = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        mag = $urandom_range(hi[31:0], lo[31:0]);
      end
      4, 5: return $urandom;
      6, 7: begin
        // Just below, at or just above a power of ten.
        lo = 1;
        repeat ($urandom_range(1, 9)) lo *= 10;
        mag = lo[31:0] + $urandom_range(0, 2) - 1;
      end
      8: begin
        mag = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 15)
                                   : 32'h7FFF_FFFF - $urandom_range(0, 15);
        return mag;
      end
      default: mag = $urandom_range(0, 20);
    endcase
    return neg ? -mag : mag;
  endfunction

  // Offer one value after an optional gap and hold it until the transfer.
  // Leave valid high afterwards; the next offer with a gap, or a drain, lowers it.
  task automatic offer_value(input logic signed [VALUE_W-1:0] value, input string spelled,
                             input int unsigned gap);
    if (gap != 0) begin
      value_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    value_if.valid <= 1'b1;
    value_if.value <= value;
    row_spelling_q.push_back(spelled);
    do @(posedge clk); while (!value_if.ready);
  endtask

  // Stop sending and wait until every owed character has come out.
  task automatic drain_text();
    value_if.valid <= 1'b0;
    @(posedge clk);
    while (text_due.size() != 0) @(posedge clk);
  endtask

  // Predict on each accepted value; sampled at the edge, before any new drive.
  always @(posedge clk) begin : watch_values
    string spelled;
    if (rst_n && value_if.valid && value_if.ready) begin
      spelled = row_spelling_q.pop_front();
      value_in_flight = value_if.value;
      if (spelled.len() != 0) queue_spelling(spelled);
      else spell_decimal(value_if.value);
    end
  end

  // Compare each transferred character with the oldest one owed.
  always @(posedge clk) begin : watch_text
    text_char_t due;
    if (rst_n && text_if.valid && text_if.ready) begin
      if (text_due.size() == 0) begin
        report_mismatch("unexpected character", '0, text_if.character);
      end else begin
        due = text_due.pop_front();
        if (text_if.character !== due.character)
          report_mismatch("character", due.character, text_if.character);
        if (text_if.last !== due.last)
          report_mismatch("last", due.last, text_if.last);
      end
    end
  end

  // Watchdog: end the run if nothing transfers for too long.
  always @(posedge clk) begin
    if (!rst_n || (value_if.valid && value_if.ready) || (text_if.valid && text_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: hold ready for a random run, then drop it for a random gap.
  initial begin
    int unsigned stall;
    text_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      text_if.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        text_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Sender: reset, directed table, a full drain, then random values.
  initial begin
    bit burst;
    mismatches  = 0;
    idle_cycles = 0;
    value_in_flight = '0;
    rst_n = 1'b0;
    value_if.valid <= 1'b0;
    value_if.value <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      offer_value(directed_rows[i].value, directed_rows[i].spelled, pick_gap());
    end
    // Hold off until the directed text has fully come out.
    drain_text();

    burst = 1'b0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      // Every 25 values, choose between back-to-back and gapped sending.
      if (n % 25 == 0) burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 79) == 0) drain_text();
      offer_value(random_value(), "", burst ? 0 : pick_gap());
    end

    drain_text();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
